/* sv/bbsp_pkg.sv */
// ----------------------------------------------------------------------------
// Bucketed bitmap slot pool - shared definitions
// Geometry constants, bucket tables, handshake payloads and control codes.
// ----------------------------------------------------------------------------
package bbsp_pkg;

    // Pool geometry
    localparam int FIRST_BUCKET_SLOTS = 8;
    localparam int MAX_BUCKET_SLOTS   = 64;
    localparam int MAX_BUCKETS        = 8;
    localparam int DATA_WIDTH         = 32;
    localparam int SIZE_GROWTH        = 2;

    // Port field widths
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Slots in bucket k: doubles from the first size, capped
    function automatic int bucket_slots(input int k);
        int s;
        s = FIRST_BUCKET_SLOTS;
        for (int i = 0; i < k; i++)
        begin
            s = s * SIZE_GROWTH;
            if (s > MAX_BUCKET_SLOTS)
                s = MAX_BUCKET_SLOTS;
        end
        return s;
    endfunction

    // First global slot of bucket k
    function automatic int bucket_base(input int k);
        int b;
        b = 0;
        for (int i = 0; i < k; i++)
            b = b + bucket_slots(i);
        return b;
    endfunction

    // Derived sizes
    localparam int POOL_SLOTS = bucket_base(MAX_BUCKETS);
    localparam int ROW_W      = (FIRST_BUCKET_SLOTS > MAX_BUCKET_SLOTS) ?
                                FIRST_BUCKET_SLOTS : MAX_BUCKET_SLOTS;
    localparam int OFF_W      = (ROW_W > 1) ? $clog2(ROW_W) : 1;
    localparam int BUCKET_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int OPENED_W   = $clog2(MAX_BUCKETS + 1);
    localparam int ADDR_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_e_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BEYOND    = 2'd2,
        ST_NOT_TAKEN = 2'd3
    } status_e_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_OUT
    } state_e_t;

    // Request item
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  slot_number;
        logic [VALUE_W-1:0] item_value;
    } bbsp_in_t;

    // Response item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   result_slot;
        logic [VALUE_W-1:0]  read_value;
        logic                slot_taken;
        logic [COUNT_W-1:0]  live_count;
    } bbsp_out_t;

    // Controller to datapath strobes
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic load_out;
    } dp_cmd_t;

endpackage

/* sv/bbsp_ctrl.sv */
// ----------------------------------------------------------------------------
// Slot pool controller
// Sequences one item through capture, read, update and output hand-off.
// ----------------------------------------------------------------------------
module bbsp_ctrl
    import bbsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output dp_cmd_t cmd
);

    state_e_t state_reg, state_next;
    logic     out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and strobes
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !rsp_stall))
        else $error("result overwritten while held");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_READ))
        else $error("accepted item not sequenced to read");

    a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == S_OUT))
        else $error("update not followed by output hand-off");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.read, cmd.exec, cmd.load_out}))
        else $error("more than one datapath strobe");
`endif

endmodule

/* sv/bbsp_dp.sv */
// ----------------------------------------------------------------------------
// Slot pool datapath
// Bucket flags, occupancy rows, data store, slot search and result register.
// ----------------------------------------------------------------------------
module bbsp_dp
    import bbsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  bbsp_in_t  req,
    output bbsp_out_t rsp
);

    // Constant bucket tables
    logic [SLOT_W-1:0] base_tab [MAX_BUCKETS];
    logic [SLOT_W-1:0] end_tab  [MAX_BUCKETS];
    logic [ROW_W-1:0]  mask_tab [MAX_BUCKETS];

    for (genvar g = 0; g < MAX_BUCKETS; g++)
    begin : g_tab
        assign base_tab[g] = SLOT_W'(bucket_base(g));
        assign end_tab[g]  = SLOT_W'(bucket_base(g + 1));
        assign mask_tab[g] = {ROW_W{1'b1}} >> (ROW_W - bucket_slots(g));
    end

    // Pool state
    logic [MAX_BUCKETS-1:0] full_reg;
    logic [MAX_BUCKETS-1:0] row_valid_reg;
    logic [OPENED_W-1:0]    opened_reg;
    logic [COUNT_W-1:0]     occupied_reg, occupied_next;

    // Memories
    logic [ROW_W-1:0]      occ_mem  [MAX_BUCKETS];
    logic [DATA_WIDTH-1:0] item_mem [POOL_SLOTS];

    // Captured item
    cmd_e_t                cmd_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [BUCKET_W-1:0]   bucket_reg, bucket_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    status_e_t             pre_reg, pre_next;
    logic                  open_reg, open_next;
    logic                  found;

    // Read data
    logic [ROW_W-1:0]      occ_row_reg;
    logic [DATA_WIDTH-1:0] item_rd_reg;
    logic                  item_rd_en;

    // Update logic
    logic [ROW_W-1:0]  free_bits, lowest, ins_row, rem_row;
    logic [OFF_W-1:0]  ins_off;
    logic [SLOT_W-1:0] ins_slot;
    logic              ins_full, was_taken, access_ok, do_insert, do_remove;

    bbsp_out_t res_reg, res_next, out_reg;

    // Bucket choice at capture: first non-full opened bucket, else the next bucket to open; or locate slot
    always_comb
    begin
        found       = 1'b0;
        bucket_next = '0;
        offset_next = '0;
        pre_next    = ST_OK;
        open_next   = 1'b0;
        case (req.command)
            CMD_INSERT:
            begin
                for (int k = 0; k < MAX_BUCKETS; k++)
                begin
                    if (!found && (OPENED_W'(k) < opened_reg) && !full_reg[k])
                    begin
                        found       = 1'b1;
                        bucket_next = BUCKET_W'(k);
                    end
                end
                if (!found)
                begin
                    if (opened_reg < OPENED_W'(MAX_BUCKETS))
                    begin
                        bucket_next = opened_reg[BUCKET_W-1:0];
                        open_next   = 1'b1;
                    end
                    else
                    begin
                        pre_next = ST_FULL;
                    end
                end
            end
            CMD_REMOVE, CMD_GET:
            begin
                // buckets are contiguous from slot zero
                for (int k = 0; k < MAX_BUCKETS; k++)
                begin
                    if (!found && (OPENED_W'(k) < opened_reg)
                        && (req.slot_number < end_tab[k]))
                    begin
                        found       = 1'b1;
                        bucket_next = BUCKET_W'(k);
                    end
                end
                if (found)
                    offset_next = OFF_W'(req.slot_number - base_tab[bucket_next]);
                else
                    pre_next = ST_BEYOND;
            end
            default:
            begin
                pre_next = ST_OK;
            end
        endcase
    end

    // Capture registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg    <= cmd_e_t'(req.command);
            slot_reg   <= req.slot_number;
            value_reg  <= req.item_value[DATA_WIDTH-1:0];
            bucket_reg <= bucket_next;
            offset_reg <= offset_next;
            pre_reg    <= pre_next;
            open_reg   <= open_next;
        end
    end

    assign access_ok  = (pre_reg == ST_OK) && ((cmd_reg == CMD_REMOVE) || (cmd_reg == CMD_GET));
    assign item_rd_en = access_ok;

    // Lowest free slot of the chosen bucket
    assign free_bits = ~occ_row_reg & mask_tab[bucket_reg];
    assign lowest    = free_bits & (~free_bits + ROW_W'(1));

    always_comb
    begin
        ins_off = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (lowest[i])
                ins_off = ins_off | OFF_W'(i);
        end
    end

    assign ins_row   = occ_row_reg | lowest;
    assign ins_full  = ((ins_row & mask_tab[bucket_reg]) == mask_tab[bucket_reg]);
    assign ins_slot  = base_tab[bucket_reg] + SLOT_W'(ins_off);
    assign was_taken = occ_row_reg[offset_reg];
    assign rem_row   = occ_row_reg & ~(ROW_W'(1) << offset_reg);
    assign do_insert = (cmd_reg == CMD_INSERT) && (pre_reg == ST_OK);
    assign do_remove = (cmd_reg == CMD_REMOVE) && access_ok && was_taken;

    // Live count after this item
    always_comb
    begin
        if (do_insert)
            occupied_next = occupied_reg + COUNT_W'(1);
        else if (do_remove)
            occupied_next = occupied_reg - COUNT_W'(1);
        else
            occupied_next = occupied_reg;
    end

    // Result assembly
    always_comb
    begin
        res_next             = '0;
        res_next.status      = pre_reg;
        res_next.result_slot = slot_reg;
        res_next.live_count  = occupied_next;
        if (cmd_reg == CMD_INSERT)
            res_next.result_slot = do_insert ? ins_slot : '0;
        if (access_ok)
        begin
            if (was_taken)
            begin
                res_next.slot_taken = 1'b1;
                res_next.read_value = VALUE_W'(item_rd_reg);
            end
            else
            begin
                res_next.status = ST_NOT_TAKEN;
            end
        end
    end

    // Pool state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg      <= '0;
            row_valid_reg <= '0;
            opened_reg    <= '0;
            occupied_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            occupied_reg <= occupied_next;
            if (do_insert)
            begin
                full_reg[bucket_reg]      <= ins_full;
                row_valid_reg[bucket_reg] <= 1'b1;
                if (open_reg)
                    opened_reg <= opened_reg + OPENED_W'(1);
            end
            else if (do_remove)
            begin
                full_reg[bucket_reg] <= 1'b0;
            end
        end
    end

    // Occupancy rows: an unwritten row reads as empty
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_insert)
            occ_mem[bucket_reg] <= ins_row;
        else if (cmd.exec && do_remove)
            occ_mem[bucket_reg] <= rem_row;
        if (cmd.read)
            occ_row_reg <= row_valid_reg[bucket_reg] ? occ_mem[bucket_reg] : '0;
    end

    // Data store
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_insert)
            item_mem[ins_slot[ADDR_W-1:0]] <= value_reg;
        if (cmd.read && item_rd_en)
            item_rd_reg <= item_mem[slot_reg[ADDR_W-1:0]];
    end

    // Result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            res_reg <= res_next;
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    assign rsp = out_reg;

endmodule

/* sv/bucketed_bitmap_slot_pool.sv */
// ----------------------------------------------------------------------------
// Bucketed bitmap slot pool
// Each item passes through capture, row and data read, update and output
// hand-off in turn; a new request is stalled until the previous item has
// been handed to the output register.
// The output register lets a new item be taken while a result is still held.
// Reset clears bucket flags, row valid bits and counters at once; no clearing
// pass, the data store is undefined until written.
// ----------------------------------------------------------------------------
module bucketed_bitmap_slot_pool
    import bbsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  bbsp_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output bbsp_out_t rsp
);

    dp_cmd_t cmd;

    // Sequencer
    bbsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Pool state and search
    bbsp_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bucketed bitmap slot pool
// Feeds insert, remove, get and no-op items through the request channel,
// predicts every response with a shadow of the pool and checks each response
// field by field, under several idling and stalling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import bbsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SLOT_TOP       = (1 << SLOT_W) - 1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    bbsp_in_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    bbsp_out_t rsp;

    // Stimulus and expectation stores
    bbsp_in_t  req_backlog[$];
    bbsp_out_t awaited_rsps[$];
    bbsp_out_t want_rsp;
    logic      req_went = 1'b0;

    // Idling knobs and the long receiver hold-off
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    int fail_count = 0;
    int quiet_cycles = 0;

    // Shadow of the pool
    int                 bucket_len[MAX_BUCKETS];
    int                 bucket_first[MAX_BUCKETS];
    logic               pool_taken[POOL_SLOTS];
    logic [VALUE_W-1:0] pool_words[POOL_SLOTS];
    logic               bucket_full[MAX_BUCKETS];
    int                 buckets_open = 0;
    int                 live_slots = 0;

    bucketed_bitmap_slot_pool u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Store a word in the lowest free slot of bucket k; flag it full if that
    // was its last free slot
    function automatic int fill_bucket(input int k, input logic [VALUE_W-1:0] word);
        int s;
        int got;
        logic any_free;
        got = -1;
        any_free = 1'b0;
        for (s = bucket_first[k]; s < bucket_first[k] + bucket_len[k]; s++)
        begin
            if (!pool_taken[s])
            begin
                if (got < 0)
                    got = s;
                else
                    any_free = 1'b1;
            end
        end
        pool_taken[got] = 1'b1;
        pool_words[got] = word;
        live_slots++;
        if (!any_free)
            bucket_full[k] = 1'b1;
        return got;
    endfunction

    // Apply one command to the shadow pool and give the response it causes
    function automatic bbsp_out_t pool_apply(input bbsp_in_t it);
        bbsp_out_t r;
        int k;
        int b;
        logic placed;
        r = '0;
        r.result_slot = it.slot_number;
        case (it.command)
            CMD_INSERT:
            begin
                r.result_slot = '0;
                placed = 1'b0;
                for (k = 0; k < buckets_open && !placed; k++)
                begin
                    if (!bucket_full[k])
                    begin
                        r.result_slot = SLOT_W'(fill_bucket(k, it.item_value));
                        placed = 1'b1;
                    end
                end
                // All opened buckets full: open the next one if allowed
                if (!placed)
                begin
                    if (buckets_open < MAX_BUCKETS)
                    begin
                        k = buckets_open;
                        buckets_open++;
                        bucket_full[k] = 1'b0;
                        r.result_slot = SLOT_W'(fill_bucket(k, it.item_value));
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            CMD_REMOVE, CMD_GET:
            begin
                k = -1;
                for (b = 0; b < buckets_open; b++)
                begin
                    if (it.slot_number >= bucket_first[b] &&
                        it.slot_number < bucket_first[b] + bucket_len[b])
                        k = b;
                end
                if (k < 0)
                    r.status = ST_BEYOND;
                else if (!pool_taken[it.slot_number])
                    r.status = ST_NOT_TAKEN;
                else
                begin
                    r.slot_taken = 1'b1;
                    r.read_value = pool_words[it.slot_number];
                    if (it.command == CMD_REMOVE)
                    begin
                        pool_taken[it.slot_number] = 1'b0;
                        bucket_full[k] = 1'b0;
                        live_slots--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.live_count = COUNT_W'(live_slots);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        fail_count++;
        if (fail_count <= 200)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic logic [VALUE_W-1:0] rand_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 16)
            return '1;
        return $urandom;
    endfunction

    task automatic queue_req(input cmd_e_t c, input int slot, input logic [VALUE_W-1:0] word);
        bbsp_in_t it;
        it.command = c;
        it.slot_number = slot[SLOT_W-1:0];
        it.item_value = word;
        req_backlog.push_back(it);
    endtask

    // Mostly slots inside the pool, some beyond its last bucket
    function automatic int pick_slot();
        if ($urandom_range(99) < 85)
            return $urandom_range(POOL_SLOTS - 1);
        return $urandom_range(SLOT_TOP, POOL_SLOTS);
    endfunction

    // Random mix of commands; the remainder of the percentages are no-ops
    task automatic queue_mix(input int n, input int pct_ins, input int pct_rem,
                             input int pct_get);
        int roll;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < pct_ins)
                queue_req(CMD_INSERT, $urandom_range(SLOT_TOP), rand_word());
            else if (roll < pct_ins + pct_rem)
                queue_req(CMD_REMOVE, pick_slot(), rand_word());
            else if (roll < pct_ins + pct_rem + pct_get)
                queue_req(CMD_GET, pick_slot(), rand_word());
            else
                queue_req(CMD_NOP, $urandom_range(SLOT_TOP), rand_word());
        end
    endtask

    // Remove n distinct slots in shuffled order, some read first, with inserts
    // refilling the holes now and then
    task automatic queue_sweep(input int n);
        int order[POOL_SLOTS];
        int i;
        int j;
        int tmp;
        for (i = 0; i < POOL_SLOTS; i++)
            order[i] = i;
        for (i = POOL_SLOTS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 30)
                queue_req(CMD_GET, order[i], rand_word());
            queue_req(CMD_REMOVE, order[i], rand_word());
            if ($urandom_range(99) < 15)
                queue_req(CMD_INSERT, $urandom_range(SLOT_TOP), rand_word());
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_valid || awaited_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: next item once the current one has gone, or an idle cycle
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_went)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Accepted requests go through the shadow pool
    always @(posedge clk)
    begin
        req_went <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            awaited_rsps.push_back(pool_apply(req));
    end

    // Response stall: a long hold-off when asked, otherwise random
    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsps.size() == 0)
                report_mismatch("response with none awaited, slot",
                                VALUE_W'(rsp.result_slot), '0);
            else
            begin
                want_rsp = awaited_rsps.pop_front();
                if (rsp.status !== want_rsp.status)
                    report_mismatch("status", VALUE_W'(rsp.status),
                                    VALUE_W'(want_rsp.status));
                if (rsp.result_slot !== want_rsp.result_slot)
                    report_mismatch("result_slot", VALUE_W'(rsp.result_slot),
                                    VALUE_W'(want_rsp.result_slot));
                if (rsp.read_value !== want_rsp.read_value)
                    report_mismatch("read_value", rsp.read_value, want_rsp.read_value);
                if (rsp.slot_taken !== want_rsp.slot_taken)
                    report_mismatch("slot_taken", VALUE_W'(rsp.slot_taken),
                                    VALUE_W'(want_rsp.slot_taken));
                if (rsp.live_count !== want_rsp.live_count)
                    report_mismatch("live_count", VALUE_W'(rsp.live_count),
                                    VALUE_W'(want_rsp.live_count));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("bucketed_bitmap_slot_pool test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int span;
        int first;
        int k;
        int s;

        // Bucket geometry and an empty shadow pool
        span = FIRST_BUCKET_SLOTS;
        first = 0;
        for (k = 0; k < MAX_BUCKETS; k++)
        begin
            bucket_len[k] = span;
            bucket_first[k] = first;
            bucket_full[k] = 1'b0;
            first = first + span;
            span = (span * SIZE_GROWTH > MAX_BUCKET_SLOTS) ? MAX_BUCKET_SLOTS
                                                           : span * SIZE_GROWTH;
        end
        for (s = 0; s < POOL_SLOTS; s++)
        begin
            pool_taken[s] = 1'b0;
            pool_words[s] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pool, extremes, bucket opening, holes, no-ops
        queue_req(CMD_GET, 0, '0);
        queue_req(CMD_REMOVE, SLOT_TOP, '1);
        queue_req(CMD_NOP, 'h155, '1);
        queue_req(CMD_INSERT, SLOT_TOP, '1);
        queue_req(CMD_INSERT, 0, '0);
        repeat (6)
            queue_req(CMD_INSERT, $urandom_range(SLOT_TOP), $urandom);
        queue_req(CMD_INSERT, 0, 'hA5A5_A5A5);
        queue_req(CMD_GET, 0, '0);
        queue_req(CMD_GET, 1, '1);
        queue_req(CMD_GET, 9, '0);
        queue_req(CMD_GET, 24, '0);
        queue_req(CMD_REMOVE, 3, '0);
        queue_req(CMD_REMOVE, 3, '0);
        queue_req(CMD_GET, 3, '0);
        queue_req(CMD_INSERT, 0, 'h5A5A_5A5A);
        queue_req(CMD_GET, 3, '0);
        queue_req(CMD_REMOVE, 8, '0);
        queue_req(CMD_INSERT, SLOT_TOP, $urandom);
        queue_req(CMD_NOP, SLOT_TOP, '0);
        wait_drained();

        // Fill to full with no idling; long receiver hold-off at the start
        queue_mix(470, 90, 4, 4);
        hold_asked = hold_asked + 1;
        wait_drained();

        // Sender mostly idle: drain a good part of the pool
        send_idle_pct = 86;
        queue_sweep(200);
        wait_drained();

        // Receiver mostly stalling: balanced churn
        send_idle_pct = 0;
        recv_stall_pct = 86;
        queue_mix(450, 45, 35, 15);
        wait_drained();

        // Both sides idling: drain again, then refill
        send_idle_pct = 31;
        recv_stall_pct = 31;
        queue_sweep(150);
        queue_mix(320, 80, 8, 8);
        wait_drained();

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("bucketed_bitmap_slot_pool test passed");
        else
            $display("bucketed_bitmap_slot_pool test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/bbsp_pkg.sv
sv/bbsp_ctrl.sv
sv/bbsp_dp.sv
sv/bucketed_bitmap_slot_pool.sv
sim/tb_top.sv
